/* rtl/sliding_window_median_filter_top_defines.svh */
// Assertion macros shared by the checker of the median filter.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWMF_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SWMF_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/swmf_pkg.sv */
package swmf_pkg;

    // Default sizing of the block.
    localparam int DEF_MAX_WINDOW  = 64;
    localparam int DEF_SAMPLE_BITS = 32;

    // Register widths and the configuration port.
    localparam int WS_W      = 7;
    localparam int SE_W      = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEND_EVERY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEND_FIRST_AT = 2'd2;

    // Register values after reset.
    localparam logic [WS_W-1:0] DEF_WINDOW_SIZE   = 7'd5;
    localparam logic [SE_W-1:0] DEF_SEND_EVERY    = 16'd5;
    localparam logic [SE_W-1:0] DEF_SEND_FIRST_AT = 16'd1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CNT   = 7'b0000010,
        S_CAND  = 7'b0000100,
        S_LOAD  = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_CHECK = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    // Control of the rank unit. A load clears the counts and takes a new
    // reference value, either the entry just read or the largest sample.
    typedef struct packed {
        logic load;
        logic use_max;
        logic acc;
    } rank_ctrl_t;

endpackage

/* rtl/swmf_ram.sv */
module swmf_ram
    import swmf_pkg::*;
#(
    parameter int WIDTH = DEF_SAMPLE_BITS + 1,
    parameter int DEPTH = DEF_MAX_WINDOW
)(
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/swmf_rank.sv */
module swmf_rank
    import swmf_pkg::*;
#(
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)(
    input  logic                                 clk,
    input  rank_ctrl_t                           ctrl,
    input  logic [SAMPLE_BITS-1:0]               ent_sample,
    input  logic                                 ent_valid,
    output logic [SAMPLE_BITS-1:0]               cand,
    output logic [$clog2(MAX_WINDOW + 1)-1:0]    less,
    output logic [$clog2(MAX_WINDOW + 1)-1:0]    leq
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);

    logic [SAMPLE_BITS-1:0] cand_reg;
    logic [CNT_W-1:0]       less_reg;
    logic [CNT_W-1:0]       leq_reg;
    logic                   is_lt;
    logic                   is_eq;

    // The single signed comparator that every pass shares.
    assign is_lt = $signed(ent_sample) < $signed(cand_reg);
    assign is_eq = ent_sample == cand_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cand_reg <= ctrl.use_max ? {1'b0, {(SAMPLE_BITS - 1){1'b1}}} : ent_sample;
            less_reg <= '0;
            leq_reg  <= '0;
        end
        else if (ctrl.acc && ent_valid)
        begin
            less_reg <= less_reg + CNT_W'(is_lt);
            leq_reg  <= leq_reg + CNT_W'(is_lt | is_eq);
        end
    end

    assign cand = cand_reg;
    assign less = less_reg;
    assign leq  = leq_reg;

endmodule

/* rtl/sliding_window_median_filter_top.sv */
// A sample that owes no result is written into the window as it is accepted. A result takes a count pass
// over the window fill F, then a ranking pass over the window for each valid candidate examined
// (an invalid one is only read and skipped), and finally a write into the output register.
// Throughput: one sample per cycle while no result is due, otherwise one per computation.
// Reset (asynchronous, active low) empties the window, loads window size 5, period 5, first 1.
module sliding_window_median_filter_top
    import swmf_pkg::*;
#(
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration write port.
    input  logic                                   cfg_we,
    input  logic [CFG_IDX_W-1:0]                   cfg_index,
    input  logic [CFG_W-1:0]                       cfg_wdata,
    // Sample stream.
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // sample
    input  logic                                   s_axis_tuser,  // sample_valid
    // Result stream.
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [((SAMPLE_BITS + 8) / 8) * 8-1:0] m_axis_tdata,  // median_doubled
    output logic                                   m_axis_tuser   // median_valid
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int OUT_W = ((SAMPLE_BITS + 8) / 8) * 8;
    localparam int ENT_W = SAMPLE_BITS + 1;

    // Configuration registers as written, and the effective values derived from them.
    logic [WS_W-1:0]  ws_reg, ws_next;
    logic [SE_W-1:0]  every_raw_reg, every_raw_next;
    logic [SE_W-1:0]  first_raw_reg, first_raw_next;
    logic [CNT_W-1:0] size_reg, size_next;
    logic [SE_W-1:0]  every_reg, every_next;

    // Window bookkeeping and the decimation counter.
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [SE_W-1:0]  send_reg, send_next;

    // Sequencer.
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             rd_pend_reg, rd_pend_next;
    logic [CNT_W-1:0] cand_idx_reg, cand_idx_next;
    logic [CNT_W-1:0] k_lo_reg, k_lo_next;
    logic [CNT_W-1:0] k_hi_reg, k_hi_next;
    logic             lo_found_reg, lo_found_next;
    logic             hi_found_reg, hi_found_next;
    logic             res_ok_reg, res_ok_next;
    logic [SAMPLE_BITS-1:0] lo_val_reg, lo_val_next;
    logic [SAMPLE_BITS-1:0] hi_val_reg, hi_val_next;

    // Output register.
    logic             out_valid_reg, out_valid_next;
    logic             out_flag_reg, out_flag_next;
    logic [ENT_W-1:0] out_data_reg, out_data_next;

    // Memory and rank unit connections.
    logic             ram_we;
    logic [PTR_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [ENT_W-1:0] ram_rdata;
    rank_ctrl_t       rank_ctrl;
    logic [SAMPLE_BITS-1:0] rank_cand;
    logic [CNT_W-1:0] rank_less;
    logic [CNT_W-1:0] rank_leq;

    // Configuration helpers.
    logic             cfg_hit;
    logic [31:0]      size_wide;
    logic [SE_W-1:0]  every_eff;
    logic [SE_W-1:0]  first_eff;

    // Sequencer helpers.
    logic             in_acc;
    logic             scan_issue;
    logic             scan_done;
    logic             lo_hit;
    logic             hi_hit;
    logic [CNT_W-1:0] cand_idx_inc;
    logic [CNT_W:0]   wp_inc;
    logic [SE_W:0]    send_inc;
    logic [ENT_W-1:0] median_sum;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    // The window memory: each entry holds the valid flag above the sample.
    swmf_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_WINDOW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The rank unit counts how many valid entries lie below, and at or below, a reference.
    swmf_rank #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_rank (
        .clk        (clk),
        .ctrl       (rank_ctrl),
        .ent_sample (ram_rdata[SAMPLE_BITS-1:0]),
        .ent_valid  (ram_rdata[SAMPLE_BITS]),
        .cand       (rank_cand),
        .less       (rank_less),
        .leq        (rank_leq)
    );

    assign ram_we    = in_acc;
    assign ram_wdata = {s_axis_tuser, s_axis_tdata[SAMPLE_BITS-1:0]};
    assign ram_raddr = (state_reg == S_CAND) ? cand_idx_reg[PTR_W-1:0]
                                             : scan_idx_reg[PTR_W-1:0];

    // Configuration writes. Any write to a known register restarts the window, so the
    // effective size, period and counter preload are worked out from the new values.
    always_comb
    begin
        ws_next        = ws_reg;
        every_raw_next = every_raw_reg;
        first_raw_next = first_raw_reg;
        cfg_hit        = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW_SIZE:
                begin
                    ws_next = cfg_wdata[WS_W-1:0];
                    cfg_hit = 1'b1;
                end
                REG_SEND_EVERY:
                begin
                    every_raw_next = cfg_wdata[SE_W-1:0];
                    cfg_hit        = 1'b1;
                end
                REG_SEND_FIRST_AT:
                begin
                    first_raw_next = cfg_wdata[SE_W-1:0];
                    cfg_hit        = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end

        // A zero size counts as one, and a size above the memory depth saturates.
        if (ws_next == '0)
        begin
            size_wide = 32'd1;
        end
        else if (32'(ws_next) > 32'(MAX_WINDOW))
        begin
            size_wide = 32'(MAX_WINDOW);
        end
        else
        begin
            size_wide = 32'(ws_next);
        end

        // A zero period or first send counts as one; the first send is clamped to the period.
        every_eff = (every_raw_next == '0) ? SE_W'(1) : every_raw_next;
        first_eff = (first_raw_next == '0) ? SE_W'(1) : first_raw_next;
        if (first_eff > every_eff)
        begin
            first_eff = every_eff;
        end
    end

    assign size_next  = cfg_hit ? CNT_W'(size_wide) : size_reg;
    assign every_next = cfg_hit ? every_eff : every_reg;

    // Main sequencer. A sample is written straight into the window in the cycle it is
    // taken. When it is due a result, the rank unit first counts the valid entries, then
    // each valid entry in turn is ranked against the whole window until both middle
    // entries have been found.
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        wp_next        = wp_reg;
        send_next      = send_reg;
        scan_idx_next  = scan_idx_reg;
        rd_pend_next   = 1'b0;
        cand_idx_next  = cand_idx_reg;
        k_lo_next      = k_lo_reg;
        k_hi_next      = k_hi_reg;
        lo_found_next  = lo_found_reg;
        hi_found_next  = hi_found_reg;
        res_ok_next    = res_ok_reg;
        lo_val_next    = lo_val_reg;
        hi_val_next    = hi_val_reg;
        out_valid_next = out_valid_reg;
        out_flag_next  = out_flag_reg;
        out_data_next  = out_data_reg;
        rank_ctrl      = '0;

        scan_issue   = scan_idx_reg < fill_reg;
        scan_done    = !scan_issue && !rd_pend_reg;
        cand_idx_inc = cand_idx_reg + CNT_W'(1);
        wp_inc       = {1'b0, CNT_W'(wp_reg)} + (CNT_W + 1)'(1);
        send_inc     = {1'b0, send_reg} + (SE_W + 1)'(1);
        lo_hit       = (rank_less <= k_lo_reg) && (k_lo_reg < rank_leq);
        hi_hit       = (rank_less <= k_hi_reg) && (k_hi_reg < rank_leq);
        median_sum   = {lo_val_reg[SAMPLE_BITS-1], lo_val_reg}
                     + {hi_val_reg[SAMPLE_BITS-1], hi_val_reg};

        // The output register frees up as soon as its transaction completes.
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    wp_next = (wp_inc >= (CNT_W + 1)'(size_reg)) ? '0 : PTR_W'(wp_inc);
                    if (fill_reg < size_reg)
                    begin
                        fill_next = fill_reg + CNT_W'(1);
                    end
                    if (send_inc >= {1'b0, every_reg})
                    begin
                        send_next          = '0;
                        scan_idx_next      = '0;
                        rank_ctrl.load     = 1'b1;
                        rank_ctrl.use_max  = 1'b1;
                        state_next         = S_CNT;
                    end
                    else
                    begin
                        send_next = SE_W'(send_inc);
                    end
                end
            end

            S_CNT, S_SCAN:
            begin
                rank_ctrl.acc = rd_pend_reg;
                if (scan_issue)
                begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                    rd_pend_next  = 1'b1;
                end
                if (scan_done)
                begin
                    if (state_reg == S_SCAN)
                    begin
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        // Ranked against the largest sample, every valid entry counts.
                        res_ok_next   = rank_leq != '0;
                        k_lo_next     = (rank_leq - CNT_W'(1)) >> 1;
                        k_hi_next     = rank_leq >> 1;
                        lo_found_next = 1'b0;
                        hi_found_next = 1'b0;
                        cand_idx_next = '0;
                        state_next    = (rank_leq == '0) ? S_FIN : S_CAND;
                    end
                end
            end

            S_CAND:
            begin
                state_next = S_LOAD;
            end

            S_LOAD:
            begin
                if (ram_rdata[SAMPLE_BITS])
                begin
                    rank_ctrl.load = 1'b1;
                    scan_idx_next  = '0;
                    state_next     = S_SCAN;
                end
                else
                begin
                    cand_idx_next = cand_idx_inc;
                    state_next    = (cand_idx_inc >= fill_reg) ? S_FIN : S_CAND;
                end
            end

            S_CHECK:
            begin
                if (lo_hit)
                begin
                    lo_found_next = 1'b1;
                    lo_val_next   = rank_cand;
                end
                if (hi_hit)
                begin
                    hi_found_next = 1'b1;
                    hi_val_next   = rank_cand;
                end
                cand_idx_next = cand_idx_inc;
                if (((lo_found_reg || lo_hit) && (hi_found_reg || hi_hit))
                    || (cand_idx_inc >= fill_reg))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_CAND;
                end
            end

            S_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_flag_next  = res_ok_reg;
                    out_data_next  = res_ok_reg ? median_sum : '0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A configuration write empties the window and reloads the send counter.
        if (cfg_hit)
        begin
            fill_next = '0;
            wp_next   = '0;
            send_next = every_eff - first_eff;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg        <= DEF_WINDOW_SIZE;
            every_raw_reg <= DEF_SEND_EVERY;
            first_raw_reg <= DEF_SEND_FIRST_AT;
            size_reg      <= CNT_W'((32'(DEF_WINDOW_SIZE) > 32'(MAX_WINDOW))
                                    ? 32'(MAX_WINDOW) : 32'(DEF_WINDOW_SIZE));
            every_reg     <= DEF_SEND_EVERY;
            fill_reg      <= '0;
            wp_reg        <= '0;
            send_reg      <= DEF_SEND_EVERY - DEF_SEND_FIRST_AT;
            state_reg     <= S_IDLE;
            scan_idx_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            cand_idx_reg  <= '0;
            lo_found_reg  <= 1'b0;
            hi_found_reg  <= 1'b0;
            res_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ws_reg        <= ws_next;
            every_raw_reg <= every_raw_next;
            first_raw_reg <= first_raw_next;
            size_reg      <= size_next;
            every_reg     <= every_next;
            fill_reg      <= fill_next;
            wp_reg        <= wp_next;
            send_reg      <= send_next;
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            rd_pend_reg   <= rd_pend_next;
            cand_idx_reg  <= cand_idx_next;
            lo_found_reg  <= lo_found_next;
            hi_found_reg  <= hi_found_next;
            res_ok_reg    <= res_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        k_lo_reg     <= k_lo_next;
        k_hi_reg     <= k_hi_next;
        lo_val_reg   <= lo_val_next;
        hi_val_reg   <= hi_val_next;
        out_flag_reg <= out_flag_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_flag_reg;
    assign m_axis_tdata  = OUT_W'(out_data_reg);

endmodule

/* rtl/swmf_checker.sv */
`include "sliding_window_median_filter_top_defines.svh"

module swmf_checker
    import swmf_pkg::*;
#(
    parameter int OUT_W = ((DEF_SAMPLE_BITS + 8) / 8) * 8
)(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic             m_axis_tuser
);

    // A stalled result keeps its transaction intact.
    `SWMF_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // A window with no valid sample reports a zero median.
    `SWMF_HOLDS(a_invalid_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "invalid result with non-zero data")

    // A new result only appears after the block has been busy working it out.
    `SWMF_HOLDS(a_result_after_busy, $rose(m_axis_tvalid), $past(!s_axis_tready), "result appeared while the block was idle")

endmodule

bind sliding_window_median_filter_top swmf_checker #(
    .OUT_W (((SAMPLE_BITS + 8) / 8) * 8)
) u_swmf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
